// File: rtl/seven_segment_serial_writer_defines.svh
// Assertion macros shared by the seven-segment serial writer RTL.
`ifndef SEVEN_SEGMENT_SERIAL_WRITER_DEFINES_SVH
`define SEVEN_SEGMENT_SERIAL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SSW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("seven segment writer check failed");
// Check a property on every clock edge, reset included.
`define SSW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("seven segment writer check failed");
`else
`define SSW_ASSERT(label, prop)
`define SSW_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: rtl/ssw_pkg.sv
// Constants and types for the seven-segment serial writer.
package ssw_pkg;

  typedef logic [7:0] byte_t;

  // Number of digit positions in a frame (1 to 6).
  localparam int DIGITS = 4;

  // Index width into the latched digit bytes.
  localparam int FRAME_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Command bytes of the serial protocol.
  localparam byte_t CMD_DATA   = 8'h40;
  localparam byte_t CMD_ADDR   = 8'hC0;
  localparam byte_t CTRL_RESET = 8'h8C;

  // Last bit of a byte, LSB first.
  localparam logic [2:0] LAST_BIT = 3'd7;

  // Byte counter value of the last digit byte of a frame.
  localparam logic [2:0] BYTE_LAST = 3'(DIGITS + 1);

  // Number of digit inputs on the port.
  localparam int SEG_INPUTS = 4;

endpackage

// File: rtl/seven_segment_serial_writer.sv
// Seven-segment serial writer: phase sequencer for a two-wire display driver.
//
// Each accepted input beat is one timing phase; each gives exactly one result
// beat with the clock and data line levels for that phase, from the output
// register. The block takes one beat per cycle: the phase sequencer
// updates in the same cycle as the output register loads, and in_stall is
// raised only while a result is held by out_stall. A frame runs start, 0x40,
// stop, start, 0xC0, the digit bytes, stop; a control request runs start, the
// control byte, stop. Bytes go LSB first, three phases a bit and two ack phases
// a byte. Start requests seen mid-transaction are dropped. control_byte may be
// written at any time; cfg_ready is always high.
`include "seven_segment_serial_writer_defines.svh"

module seven_segment_serial_writer (
  input  logic           clk,
  input  logic           rst,
  // configuration write
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  ssw_pkg::byte_t control_byte,
  // phase input
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           start_request,
  input  logic           control_only,
  input  ssw_pkg::byte_t seg_first,
  input  ssw_pkg::byte_t seg_second,
  input  ssw_pkg::byte_t seg_third,
  input  ssw_pkg::byte_t seg_fourth,
  input  logic           dio_in,
  // line levels out
  output logic           out_valid,
  input  logic           out_stall,
  output logic           clk_out,
  output logic           dio_out,
  output logic           dio_drive,
  output logic           busy_res,
  output logic           ack_missing,
  output logic           done_res
);
  import ssw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_HI, PH_START_LO, PH_BIT_A, PH_BIT_B, PH_BIT_C,
    PH_ACK_LO, PH_ACK_HI, PH_STOP_LO, PH_STOP_HI
  } phase_t;

  // Sequencer state
  phase_t     phase_step, phase_step_next;
  logic [2:0] bit_index, bit_index_next;
  logic [2:0] byte_index, byte_index_next;
  logic       control_mode, control_mode_next;
  logic       ack_fail_flag, ack_fail_flag_next;
  logic       clk_level, clk_level_next;
  logic       dio_level, dio_level_next;
  byte_t      ctrl_reg;
  byte_t      frame_bytes [DIGITS];

  // Per-phase combinational values
  phase_t     phase_eff;
  logic       load_frame;
  logic       drive_next, busy_next, done_next;
  logic       in_accept;
  logic [2:0] digit_k;
  byte_t      cur_byte;
  byte_t      seg_in [SEG_INPUTS];

  assign seg_in[0] = seg_first;
  assign seg_in[1] = seg_second;
  assign seg_in[2] = seg_third;
  assign seg_in[3] = seg_fourth;

  // Hold the input while a result waits
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Pick the byte now on the wire
  assign digit_k = byte_index - 3'd2;
  always_comb begin
    if (control_mode) begin
      cur_byte = ctrl_reg;
    end else if (byte_index == 3'd0) begin
      cur_byte = CMD_DATA;
    end else if (byte_index == 3'd1) begin
      cur_byte = CMD_ADDR;
    end else if (digit_k < 3'(DIGITS)) begin
      cur_byte = frame_bytes[digit_k[FRAME_IDX_W-1:0]];
    end else begin
      cur_byte = '0;
    end
  end

  // Advance the sequencer by one phase
  always_comb begin
    load_frame         = (phase_step == PH_IDLE) && start_request;
    phase_eff          = load_frame ? PH_START_HI : phase_step;
    phase_step_next    = phase_step;
    bit_index_next     = load_frame ? 3'd0 : bit_index;
    byte_index_next    = load_frame ? 3'd0 : byte_index;
    control_mode_next  = load_frame ? control_only : control_mode;
    ack_fail_flag_next = load_frame ? 1'b0 : ack_fail_flag;
    clk_level_next     = clk_level;
    dio_level_next     = dio_level;
    drive_next         = 1'b1;
    busy_next          = 1'b1;
    done_next          = 1'b0;
    unique case (phase_eff)
      PH_START_HI: begin
        clk_level_next  = 1'b1;
        dio_level_next  = 1'b1;
        phase_step_next = PH_START_LO;
      end
      PH_START_LO: begin
        clk_level_next  = 1'b0;
        dio_level_next  = 1'b0;
        bit_index_next  = 3'd0;
        phase_step_next = PH_BIT_A;
      end
      PH_BIT_A: begin
        clk_level_next  = 1'b0;
        phase_step_next = PH_BIT_B;
      end
      PH_BIT_B: begin
        clk_level_next  = 1'b0;
        dio_level_next  = cur_byte[bit_index];
        phase_step_next = PH_BIT_C;
      end
      PH_BIT_C: begin
        clk_level_next = 1'b1;
        if (bit_index == LAST_BIT) begin
          phase_step_next = PH_ACK_LO;
        end else begin
          bit_index_next  = bit_index + 3'd1;
          phase_step_next = PH_BIT_A;
        end
      end
      PH_ACK_LO: begin
        clk_level_next  = 1'b0;
        phase_step_next = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        clk_level_next = 1'b1;
        drive_next     = 1'b0;
        if (dio_in) begin
          ack_fail_flag_next = 1'b1;
        end
        if (control_mode || byte_index == 3'd0 || byte_index >= BYTE_LAST) begin
          phase_step_next = PH_STOP_LO;
        end else begin
          byte_index_next = byte_index + 3'd1;
          bit_index_next  = 3'd0;
          phase_step_next = PH_BIT_A;
        end
      end
      PH_STOP_LO: begin
        clk_level_next  = 1'b0;
        dio_level_next  = 1'b0;
        phase_step_next = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        clk_level_next = 1'b1;
        dio_level_next = 1'b1;
        if (!control_mode && byte_index == 3'd0) begin
          byte_index_next = 3'd1;
          phase_step_next = PH_START_HI;
        end else begin
          done_next       = 1'b1;
          byte_index_next = 3'd0;
          bit_index_next  = 3'd0;
          phase_step_next = PH_IDLE;
        end
      end
      default: begin
        phase_step_next = PH_IDLE;
        busy_next       = 1'b0;
      end
    endcase
  end

  // Register state and the result on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PH_IDLE;
      bit_index     <= 3'd0;
      byte_index    <= 3'd0;
      control_mode  <= 1'b0;
      ack_fail_flag <= 1'b0;
      clk_level     <= 1'b1;
      dio_level     <= 1'b1;
      ctrl_reg      <= CTRL_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ctrl_reg <= control_byte;
      end
      if (in_accept) begin
        phase_step    <= phase_step_next;
        bit_index     <= bit_index_next;
        byte_index    <= byte_index_next;
        control_mode  <= control_mode_next;
        ack_fail_flag <= ack_fail_flag_next;
        clk_level     <= clk_level_next;
        dio_level     <= dio_level_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the digit bytes and the result flags
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (load_frame) begin
        for (int i = 0; i < DIGITS; i++) begin
          frame_bytes[i] <= (i < SEG_INPUTS) ? seg_in[i % SEG_INPUTS] : '0;
        end
      end
      dio_drive <= drive_next;
      busy_res  <= busy_next;
      done_res  <= done_next;
    end
  end

  assign clk_out     = clk_level;
  assign dio_out     = dio_level;
  assign ack_missing = ack_fail_flag;

  // The line is released only while the clock is high
  `SSW_ASSERT(a_release_clk_high, out_valid && !dio_drive |-> clk_out)
  // A finished transaction leaves the sequencer idle
  `SSW_ASSERT(a_done_idle, out_valid && done_res |-> busy_res && phase_step == PH_IDLE)
  // An idle beat without a start request reports not busy
  `SSW_ASSERT(a_idle_not_busy,
    in_accept && phase_step == PH_IDLE && !start_request |=> !busy_res && !done_res)
  // Input stalls only behind a held result
  `SSW_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall)

endmodule
